// File: hw/rtl/cfr_pkg.sv
// cfr_pkg: shared types and constants of the cobs frame receiver
package cfr_pkg;

  localparam int CNT_W         = 11;
  localparam int MAX_DECODED   = 1024;
  localparam int MAX_CODED_LEN = 1030;
  localparam logic [15:0] RESYNC_TICKS_RST = 16'd2;

  typedef enum logic [2:0] {
    MODE_ASSEMBLE = 3'b001,
    MODE_SYNC     = 3'b010,
    MODE_RESYNC   = 3'b100
  } mode_t;

  typedef enum logic [2:0] {
    KIND_BYTE    = 3'd0,
    KIND_ACCEPT  = 3'd1,
    KIND_DISCARD = 3'd2,
    KIND_LINE    = 3'd3,
    KIND_LONG    = 3'd4
  } kind_t;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic       framing_error;
    logic       parity_error;
    logic       break_seen;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        out_byte;
    logic [CNT_W-1:0]  frame_length;
    logic [31:0]       frames_accepted;
    logic [31:0]       error_count;
    logic [31:0]       too_long_count;
  } out_item_t;

endpackage

// File: hw/rtl/cfr_if.sv
// cfr_if: valid/ready channels for received words and result words
interface cfr_rx_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;
  logic       framing_error;
  logic       parity_error;
  logic       break_seen;

  modport source (output valid, action, rx_byte, framing_error, parity_error, break_seen,
                  input ready);
  modport sink (input valid, action, rx_byte, framing_error, parity_error, break_seen,
                output ready);
endinterface

interface cfr_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic [10:0] frame_length;
  logic [31:0] frames_accepted;
  logic [31:0] error_count;
  logic [31:0] too_long_count;

  modport source (output valid, kind, out_byte, frame_length, frames_accepted,
                  error_count, too_long_count, input ready);
  modport sink (input valid, kind, out_byte, frame_length, frames_accepted,
                error_count, too_long_count, output ready);
endinterface

// File: hw/rtl/cfr_in_stage.sv
// cfr_in_stage: input register holding one received word
module cfr_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cfr_pkg::in_item_t  in_item,
  input  logic               take,
  output logic               item_valid,
  output cfr_pkg::in_item_t  item
);

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// File: hw/rtl/cfr_decode.sv
// cfr_decode: frame state, cobs decode step, resync control and counters
module cfr_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               item_valid,
  input  cfr_pkg::in_item_t  item,
  input  logic               space,
  output logic               take,
  output logic               res_valid,
  output cfr_pkg::out_item_t res
);

  cfr_pkg::mode_t mode, mode_next;
  logic [15:0] resync_ticks;
  logic [15:0] resync_timer, resync_timer_next;
  logic [cfr_pkg::CNT_W-1:0] encoded_count, encoded_count_next;
  logic [cfr_pkg::CNT_W-1:0] decoded_count, decoded_count_next;
  logic [7:0]  group_remaining, group_remaining_next;
  logic        zero_owed, zero_owed_next;
  logic        frame_bad, frame_bad_next;
  logic [31:0] accepted_counter, accepted_counter_next;
  logic [31:0] error_counter, error_counter_next;
  logic [31:0] oversize_counter, oversize_counter_next;

  logic        line_err;
  logic [15:0] timer_inc;
  logic        pd_req;
  logic [7:0]  pd_byte;

  assign take      = item_valid && space;
  assign line_err  = item.framing_error || item.parity_error || item.break_seen;
  // timer saturates at all ones
  assign timer_inc = (resync_timer == 16'hFFFF) ? resync_timer : resync_timer + 16'd1;

  always_comb begin
    mode_next             = mode;
    resync_timer_next     = resync_timer;
    encoded_count_next    = encoded_count;
    decoded_count_next    = decoded_count;
    group_remaining_next  = group_remaining;
    zero_owed_next        = zero_owed;
    frame_bad_next        = frame_bad;
    accepted_counter_next = accepted_counter;
    error_counter_next    = error_counter;
    oversize_counter_next = oversize_counter;
    res_valid             = 1'b0;
    res.kind              = cfr_pkg::KIND_BYTE;
    res.out_byte          = 8'd0;
    res.frame_length      = decoded_count;
    pd_req                = 1'b0;
    pd_byte               = 8'd0;

    if (item.action == cfr_pkg::ACT_TICK) begin
      if (mode == cfr_pkg::MODE_RESYNC) begin
        resync_timer_next = timer_inc;
        if (timer_inc >= resync_ticks) begin
          mode_next = cfr_pkg::MODE_SYNC;
        end
      end
    end else begin
      case (mode)
        cfr_pkg::MODE_SYNC: begin
          encoded_count_next   = '0;
          decoded_count_next   = '0;
          group_remaining_next = 8'd0;
          zero_owed_next       = 1'b0;
          frame_bad_next       = 1'b0;
          if (item.rx_byte == 8'd0) begin
            mode_next = cfr_pkg::MODE_ASSEMBLE;
          end
        end
        cfr_pkg::MODE_ASSEMBLE: begin
          if (line_err || item.rx_byte == 8'd0 ||
              encoded_count >= cfr_pkg::CNT_W'(cfr_pkg::MAX_CODED_LEN)) begin
            // frame ends one way or another
            encoded_count_next   = '0;
            decoded_count_next   = '0;
            group_remaining_next = 8'd0;
            zero_owed_next       = 1'b0;
            frame_bad_next       = 1'b0;
            res_valid            = 1'b1;
            if (line_err) begin
              error_counter_next = error_counter + 32'd1;
              res.kind           = cfr_pkg::KIND_LINE;
              mode_next          = cfr_pkg::MODE_RESYNC;
              resync_timer_next  = 16'd0;
            end else if (item.rx_byte == 8'd0) begin
              if (encoded_count == '0) begin
                res_valid = 1'b0;
              end else if (frame_bad || decoded_count == '0) begin
                error_counter_next = error_counter + 32'd1;
                res.kind           = cfr_pkg::KIND_DISCARD;
              end else begin
                accepted_counter_next = accepted_counter + 32'd1;
                res.kind              = cfr_pkg::KIND_ACCEPT;
              end
            end else begin
              oversize_counter_next = oversize_counter + 32'd1;
              res.kind              = cfr_pkg::KIND_LONG;
              mode_next             = cfr_pkg::MODE_RESYNC;
              resync_timer_next     = 16'd0;
            end
          end else begin
            encoded_count_next = encoded_count + cfr_pkg::CNT_W'(1);
            if (group_remaining == 8'd0) begin
              // code byte: settle the zero owed by the previous group
              pd_req               = zero_owed;
              zero_owed_next       = (item.rx_byte != 8'hFF);
              group_remaining_next = item.rx_byte - 8'd1;
            end else begin
              group_remaining_next = group_remaining - 8'd1;
              pd_req               = 1'b1;
              pd_byte              = item.rx_byte;
            end
          end
        end
        default: begin
          // resync wait drops bytes
        end
      endcase
    end

    if (pd_req && !frame_bad) begin
      if (decoded_count >= cfr_pkg::CNT_W'(cfr_pkg::MAX_DECODED)) begin
        frame_bad_next = 1'b1;
      end else begin
        decoded_count_next = decoded_count + cfr_pkg::CNT_W'(1);
        res_valid          = 1'b1;
        res.kind           = cfr_pkg::KIND_BYTE;
        res.out_byte       = pd_byte;
        res.frame_length   = decoded_count + cfr_pkg::CNT_W'(1);
      end
    end

    res.frames_accepted = accepted_counter_next;
    res.error_count     = error_counter_next;
    res.too_long_count  = oversize_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resync_ticks     <= cfr_pkg::RESYNC_TICKS_RST;
      mode             <= cfr_pkg::MODE_ASSEMBLE;
      resync_timer     <= 16'd0;
      encoded_count    <= '0;
      decoded_count    <= '0;
      group_remaining  <= 8'd0;
      zero_owed        <= 1'b0;
      frame_bad        <= 1'b0;
      accepted_counter <= 32'd0;
      error_counter    <= 32'd0;
      oversize_counter <= 32'd0;
    end else begin
      if (cfg_we) begin
        resync_ticks <= cfg_wdata;
      end
      if (take) begin
        mode             <= mode_next;
        resync_timer     <= resync_timer_next;
        encoded_count    <= encoded_count_next;
        decoded_count    <= decoded_count_next;
        group_remaining  <= group_remaining_next;
        zero_owed        <= zero_owed_next;
        frame_bad        <= frame_bad_next;
        accepted_counter <= accepted_counter_next;
        error_counter    <= error_counter_next;
        oversize_counter <= oversize_counter_next;
      end
    end
  end

endmodule

// File: hw/rtl/cfr_out_fifo.sv
// cfr_out_fifo: two-entry result register with skid entry
module cfr_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cfr_pkg::out_item_t push_item,
  output logic               full,
  output logic               out_valid,
  input  logic               out_ready,
  output cfr_pkg::out_item_t head
);

  logic [1:0]         count;
  cfr_pkg::out_item_t tail;
  logic               pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd1) begin
        head <= push_item;
      end else begin
        head <= tail;
        tail <= push_item;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= push_item;
      end else begin
        tail <= push_item;
      end
    end else if (pop) begin
      head <= tail;
    end
  end

endmodule

// File: hw/rtl/cobs_frame_receiver.sv
// cobs_frame_receiver: top level of the streaming cobs frame receiver
//
// rx carries one word per item: a uart byte with its framing, parity and
// break flags (action 0) or a time tick (action 1). res carries at most one
// result word per item: a decoded byte, a frame end (accepted or discarded)
// or a fault (line error or too long). cfg_we/cfg_wdata write resync_ticks.
// Throughput is one item per cycle while the result queue has space: the
// decode step and all frame state updates run combinationally between the
// input register and the result queue. An accepted rx word passes through
// the input register and the result queue before its result shows on res.
// A two-entry result queue catches the word pushed while the sink stalls;
// with both entries taken the input register holds its word and rx.ready
// drops until res drains.
// Reset clears the frame state and all three counters, returns to frame
// assembly and sets resync_ticks to 2; both channels come up empty.
module cobs_frame_receiver (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [15:0] cfg_wdata,
  cfr_rx_if.sink    rx,
  cfr_res_if.source res
);

  cfr_pkg::in_item_t  in_item;
  cfr_pkg::in_item_t  item;
  cfr_pkg::out_item_t res_item;
  cfr_pkg::out_item_t head;
  logic item_valid;
  logic take;
  logic res_valid;
  logic full;
  logic push;

  assign in_item.action        = rx.action;
  assign in_item.rx_byte       = rx.rx_byte;
  assign in_item.framing_error = rx.framing_error;
  assign in_item.parity_error  = rx.parity_error;
  assign in_item.break_seen    = rx.break_seen;

  cfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rx.valid),
    .in_ready   (rx.ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  cfr_decode u_dec (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .space      (!full),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res_item)
  );

  assign push = take && res_valid;

  cfr_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (res_item),
    .full      (full),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .head      (head)
  );

  assign res.kind            = head.kind;
  assign res.out_byte        = head.out_byte;
  assign res.frame_length    = head.frame_length;
  assign res.frames_accepted = head.frames_accepted;
  assign res.error_count     = head.error_count;
  assign res.too_long_count  = head.too_long_count;

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("result pushed into a full queue");

  a_byte_has_length: assert property (@(posedge clk) disable iff (rst)
    push && res_item.kind == cfr_pkg::KIND_BYTE |-> res_item.frame_length != '0)
    else $error("decoded word with zero frame length");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !res.valid && !item_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule

// File: tb/cobs_frame_checker.sv
// cobs_frame_checker: predicts the result words of the cobs frame receiver and compares them
`timescale 1ns / 100ps
module cobs_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  cfr_rx_if           rx,
  cfr_res_if          res,
  output int          outstanding,
  output int          fail_count
);

  cfr_pkg::mode_t     mode;
  logic [15:0]        resync_limit;
  logic [15:0]        resync_timer;
  int                 coded_len;
  int                 payload_len;
  logic [7:0]         group_left;
  logic               zero_owed;
  logic               frame_bad;
  logic [31:0]        accepted_total;
  logic [31:0]        error_total;
  logic [31:0]        oversize_total;
  cfr_pkg::out_item_t expected_words[$];
  int                 failures = 0;

  task automatic drop_frame();
    coded_len = 0;
    payload_len = 0;
    group_left = '0;
    zero_owed = 1'b0;
    frame_bad = 1'b0;
  endtask

  task automatic push_result(input cfr_pkg::kind_t k, input logic [7:0] b, input int len);
    cfr_pkg::out_item_t r;
    r.kind = k;
    r.out_byte = b;
    r.frame_length = cfr_pkg::CNT_W'(len);
    r.frames_accepted = accepted_total;
    r.error_count = error_total;
    r.too_long_count = oversize_total;
    expected_words.push_back(r);
  endtask

  task automatic enter_resync(input cfr_pkg::kind_t k);
    int len;
    len = payload_len;
    mode = cfr_pkg::MODE_RESYNC;
    resync_timer = '0;
    drop_frame();
    push_result(k, 8'h00, len);
  endtask

  // once the payload limit is hit the frame goes quiet until its delimiter
  task automatic append_byte(input logic [7:0] b);
    if (frame_bad) return;
    if (payload_len >= cfr_pkg::MAX_DECODED) begin
      frame_bad = 1'b1;
      return;
    end
    payload_len++;
    push_result(cfr_pkg::KIND_BYTE, b, payload_len);
  endtask

  task automatic decode_word(input cfr_pkg::action_t act, input logic [7:0] b,
                             input logic line_fault);
    int   ended_len;
    int   ended_coded;
    logic ended_bad;
    if (act == cfr_pkg::ACT_TICK) begin
      if (mode == cfr_pkg::MODE_RESYNC) begin
        if (resync_timer != 16'hFFFF) resync_timer++;
        if (resync_timer >= resync_limit) mode = cfr_pkg::MODE_SYNC;
      end
      return;
    end
    if (mode == cfr_pkg::MODE_RESYNC) return;
    if (mode == cfr_pkg::MODE_SYNC) begin
      drop_frame();
      if (b == 8'h00) mode = cfr_pkg::MODE_ASSEMBLE;
      return;
    end
    if (line_fault) begin
      error_total++;
      enter_resync(cfr_pkg::KIND_LINE);
      return;
    end
    if (b == 8'h00) begin
      ended_len = payload_len;
      ended_coded = coded_len;
      ended_bad = frame_bad || payload_len == 0;
      drop_frame();
      if (ended_coded == 0) return;
      if (ended_bad) begin
        error_total++;
        push_result(cfr_pkg::KIND_DISCARD, 8'h00, ended_len);
      end else begin
        accepted_total++;
        push_result(cfr_pkg::KIND_ACCEPT, 8'h00, ended_len);
      end
      return;
    end
    if (coded_len >= cfr_pkg::MAX_CODED_LEN) begin
      oversize_total++;
      enter_resync(cfr_pkg::KIND_LONG);
      return;
    end
    coded_len++;
    if (group_left == 8'h00) begin
      // code byte: the zero owed by the previous group comes out now
      if (zero_owed) append_byte(8'h00);
      zero_owed = (b != 8'hFF);
      group_left = b - 8'd1;
      return;
    end
    group_left--;
    append_byte(b);
  endtask

  function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic check_word();
    cfr_pkg::out_item_t want;
    if (expected_words.size() == 0) begin
      $error("result word with none expected: kind %0d out_byte %0d", res.kind, res.out_byte);
      failures++;
      return;
    end
    want = expected_words.pop_front();
    failures += field_differs("kind", 32'(want.kind), 32'(res.kind));
    failures += field_differs("out_byte", 32'(want.out_byte), 32'(res.out_byte));
    failures += field_differs("frame_length", 32'(want.frame_length), 32'(res.frame_length));
    failures += field_differs("frames_accepted", want.frames_accepted, res.frames_accepted);
    failures += field_differs("error_count", want.error_count, res.error_count);
    failures += field_differs("too_long_count", want.too_long_count, res.too_long_count);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode = cfr_pkg::MODE_ASSEMBLE;
      resync_limit = cfr_pkg::RESYNC_TICKS_RST;
      resync_timer = '0;
      drop_frame();
      accepted_total = '0;
      error_total = '0;
      oversize_total = '0;
      expected_words.delete();
    end else begin
      if (cfg_we) resync_limit = cfg_wdata;
      if (rx.valid && rx.ready) begin
        decode_word(cfr_pkg::action_t'(rx.action), rx.rx_byte,
                    rx.framing_error | rx.parity_error | rx.break_seen);
      end
      if (res.valid && res.ready) check_word();
    end
    outstanding <= expected_words.size();
    fail_count <= failures;
  end

endmodule

// File: tb/cobs_frame_receiver_test.sv
// cobs_frame_receiver_test: stimulus, flow control and verdict for the cobs frame receiver
`timescale 1ns / 100ps
module cobs_frame_receiver_test;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          outstanding;
  int          fail_count;
  int          words_sent = 0;
  int          sender_calm = 0;
  int          resync_cur = 2;
  bit          no_gaps = 1'b0;
  bit          long_hold_req = 1'b0;

  cfr_rx_if  rx_ch ();
  cfr_res_if res_ch ();

  cobs_frame_receiver uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rx        (rx_ch),
    .res       (res_ch)
  );

  cobs_frame_checker watch (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .rx          (rx_ch),
    .res         (res_ch),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always #10 clk = ~clk;

  initial begin
    #50ms;
    $display("cobs_frame_receiver_test: FAIL");
    $finish;
  end

  // flags are {framing_error, parity_error, break_seen}
  task automatic send_word(input cfr_pkg::action_t act, input logic [7:0] b,
                           input logic [2:0] flags);
    int gap;
    if (no_gaps || sender_calm > 0) begin
      gap = 0;
      if (sender_calm > 0) sender_calm--;
    end else if ($urandom_range(0, 19) == 0) begin
      gap = 0;
      sender_calm = $urandom_range(10, 50);
    end else begin
      gap = $urandom_range(0, 11);
    end
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.action <= act;
    rx_ch.rx_byte <= b;
    rx_ch.framing_error <= flags[2];
    rx_ch.parity_error <= flags[1];
    rx_ch.break_seen <= flags[0];
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(cfr_pkg::ACT_BYTE, b, 3'b000);
  endtask

  task automatic send_tick();
    send_word(cfr_pkg::ACT_TICK, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
  endtask

  // wait out the resync and hunt down to a delimiter
  task automatic recover();
    repeat (resync_cur) send_tick();
    send_byte(8'h00);
  endtask

  task automatic settle();
    rx_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_resync(input logic [15:0] ticks);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    resync_cur = int'(ticks);
  endtask

  task automatic send_packet(input int longest);
    logic [7:0] payload[$];
    logic [7:0] coded[$];
    logic [7:0] run;
    logic [2:0] flags;
    int         count;
    int         zero_odds;
    int         code_at;
    int         stop;
    bit         noisy;
    bit         faulted;
    count = ($urandom_range(0, 15) == 0) ? $urandom_range(0, longest) : $urandom_range(0, 12);
    zero_odds = ($urandom_range(0, 3) == 0) ? 400 : 4;
    repeat (count) begin
      payload.push_back(($urandom_range(1, zero_odds) == 1) ? 8'h00 : 8'($urandom_range(1, 255)));
    end
    code_at = 0;
    run = 8'd1;
    coded.push_back(8'h00);
    foreach (payload[i]) begin
      if (payload[i] != 8'h00) begin
        coded.push_back(payload[i]);
        run++;
      end
      if (payload[i] == 8'h00 || run == 8'hFF) begin
        coded[code_at] = run;
        code_at = coded.size();
        coded.push_back(8'h00);
        run = 8'd1;
      end
    end
    coded[code_at] = run;
    noisy = ($urandom_range(0, 7) == 0);
    stop = noisy ? $urandom_range(0, coded.size()) : coded.size();
    faulted = 1'b0;
    for (int i = 0; i <= stop; i++) begin
      if ($urandom_range(0, 11) == 0) send_tick();
      flags = ($urandom_range(0, 79) == 0) ? 3'($urandom_range(1, 7)) : 3'b000;
      faulted |= (flags != 3'b000);
      if (i == stop) send_word(cfr_pkg::ACT_BYTE, 8'h00, flags);
      else if (noisy && $urandom_range(0, 5) == 0)
        send_word(cfr_pkg::ACT_BYTE, 8'($urandom_range(0, 255)), flags);
      else send_word(cfr_pkg::ACT_BYTE, coded[i], flags);
    end
    if (faulted) recover();
    if ($urandom_range(0, 7) == 0) send_byte(8'h00);
  endtask

  initial begin : sink_side
    int stall;
    int calm;
    calm = 0;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        stall = 250;
        long_hold_req = 1'b0;
      end else if (calm > 0) begin
        stall = 0;
        calm--;
      end else if ($urandom_range(0, 19) == 0) begin
        stall = 0;
        calm = $urandom_range(10, 50);
      end else begin
        stall = $urandom_range(0, 11);
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  initial begin : source_side
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    rx_ch.valid <= 1'b0;
    rx_ch.action <= cfr_pkg::ACT_BYTE;
    rx_ch.rx_byte <= '0;
    rx_ch.framing_error <= 1'b0;
    rx_ch.parity_error <= 1'b0;
    rx_ch.break_seen <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // back-to-back delimiter, then a frame with a trailing code byte
    send_byte(8'h00);
    send_byte(8'h03);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'h00);
    // decodes to nothing
    send_byte(8'h01);
    send_byte(8'h00);
    // group cut short by the delimiter
    send_byte(8'h05);
    send_byte(8'hAA);
    send_byte(8'h00);
    send_tick();
    // framing error, bytes dropped while waiting, flags ignored while hunting
    send_byte(8'h02);
    send_byte(8'h33);
    send_word(cfr_pkg::ACT_BYTE, 8'h44, 3'b100);
    send_word(cfr_pkg::ACT_BYTE, 8'h00, 3'b010);
    send_tick();
    send_tick();
    send_word(cfr_pkg::ACT_BYTE, 8'h07, 3'b001);
    send_byte(8'h00);
    send_byte(8'h02);
    send_word(cfr_pkg::ACT_BYTE, 8'h55, 3'b010);
    recover();
    send_word(cfr_pkg::ACT_BYTE, 8'h00, 3'b001);
    recover();

    set_resync(16'd1);
    while (words_sent < 250) send_packet(300);

    // long receiver hold-off against a gapless sender
    set_resync(16'd3);
    long_hold_req = 1'b1;
    sender_calm = 90;
    send_byte(8'd41);
    repeat (40) send_byte(8'($urandom_range(1, 255)));
    send_byte(8'h00);
    settle();
    while (words_sent < 420) send_packet(300);

    // longest resync wait, ended by a shorter setting
    set_resync(16'hFFFF);
    no_gaps = 1'b1;
    send_byte(8'h02);
    send_byte(8'h5A);
    send_word(cfr_pkg::ACT_BYTE, 8'h00, 3'b111);
    repeat (6) send_tick();
    send_byte(8'h03);
    set_resync(16'd1);
    send_tick();
    send_byte(8'h09);
    send_byte(8'h00);
    no_gaps = 1'b0;
    send_byte(8'h02);
    send_byte(8'h77);
    send_byte(8'h00);

    set_resync(16'($urandom_range(2, 6)));
    while (words_sent < 450) send_packet(300);
    // payload overflow running into an oversized encoding, longest group
    repeat (1031) send_byte(8'h01);
    recover();
    send_byte(8'hFF);
    repeat (254) send_byte(8'($urandom_range(1, 255)));
    send_byte(8'h00);

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("cobs_frame_receiver_test: PASS");
    end else begin
      $display("cobs_frame_receiver_test: FAIL");
    end
    $finish;
  end

endmodule
